// ===== sv/ihq_pkg.sv =====
package ihq_pkg;

    localparam int KIND_W      = 2;
    localparam int KEY_W       = 6;
    localparam int PRIO_IN_W   = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_PEEK   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_UNCHANGED = 3'd3,
        ST_ABSENT    = 3'd4,
        ST_PRESENT   = 3'd5
    } status_t;

    typedef struct packed {
        logic latch;
        logic look;
        logic check;
        logic rdlast;
        logic lastp;
        logic up_rd;
        logic upk;
        logic upp;
        logic dn_rd;
        logic dnk;
        logic dnp;
        logic place;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic chk_done;
        logic chk_up;
        logic chk_dn;
        logic chk_last;
        logic root;
        logic leaf;
        logic up_swap;
        logic dn_swap;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/ihq_ctrl.sv =====
module ihq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output ihq_pkg::cmd_t  cmd,
    input  ihq_pkg::sts_t  sts
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_LOOK   = 13'b0000000000010,
        S_CHECK  = 13'b0000000000100,
        S_RDLAST = 13'b0000000001000,
        S_LASTP  = 13'b0000000010000,
        S_UP     = 13'b0000000100000,
        S_UPK    = 13'b0000001000000,
        S_UPP    = 13'b0000010000000,
        S_DN     = 13'b0000100000000,
        S_DNK    = 13'b0001000000000,
        S_DNP    = 13'b0010000000000,
        S_PLACE  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_LOOK;
            S_LOOK:   state_next = S_CHECK;
            S_CHECK: begin
                if (sts.chk_up)        state_next = S_UP;
                else if (sts.chk_dn)   state_next = S_DN;
                else if (sts.chk_last) state_next = S_RDLAST;
                else                   state_next = S_DONE;
            end
            S_RDLAST: state_next = S_LASTP;
            S_LASTP:  state_next = S_DN;
            S_UP:     state_next = sts.root ? S_PLACE : S_UPK;
            S_UPK:    state_next = S_UPP;
            S_UPP:    state_next = sts.up_swap ? S_UP : S_PLACE;
            S_DN:     state_next = sts.leaf ? S_PLACE : S_DNK;
            S_DNK:    state_next = S_DNP;
            S_DNP:    state_next = sts.dn_swap ? S_DN : S_PLACE;
            S_PLACE:  state_next = S_DONE;
            S_DONE:   if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.latch  = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.look   = (state_reg == S_LOOK);
    assign cmd.check  = (state_reg == S_CHECK);
    assign cmd.rdlast = (state_reg == S_RDLAST);
    assign cmd.lastp  = (state_reg == S_LASTP);
    assign cmd.up_rd  = (state_reg == S_UP) && !sts.root;
    assign cmd.upk    = (state_reg == S_UPK);
    assign cmd.upp    = (state_reg == S_UPP);
    assign cmd.dn_rd  = (state_reg == S_DN) && !sts.leaf;
    assign cmd.dnk    = (state_reg == S_DNK);
    assign cmd.dnp    = (state_reg == S_DNP);
    assign cmd.place  = (state_reg == S_PLACE);
    assign cmd.emit   = (state_reg == S_DONE) && sts.out_free;

`ifndef ASSERT_OFF
    a_ready_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.emit)
        else $error("emit while accepting");
    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> s_tready)
        else $error("not idle after emit");
    a_latch_look: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch |=> cmd.look)
        else $error("lookup skipped");
`endif

endmodule

// ===== sv/ihq_dp.sv =====
module ihq_dp #(
    parameter int SLOTS         = 64,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  ihq_pkg::cmd_t                            cmd,
    output ihq_pkg::sts_t                            sts,
    input  logic [ihq_pkg::KIND_W-1:0]               in_kind,
    input  logic [ihq_pkg::KEY_W-1:0]                in_key,
    input  logic signed [ihq_pkg::PRIO_IN_W-1:0]     in_prio,
    input  logic                                     m_tready,
    output logic                                     m_tvalid,
    output logic [ihq_pkg::STATUS_W-1:0]             out_status,
    output logic [ihq_pkg::KEY_W-1:0]                out_top,
    output logic [ihq_pkg::COUNT_OUT_W-1:0]          out_count
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PD = (SLOTS < 64) ? SLOTS : 64;
    localparam int PW = (PD > 1) ? $clog2(PD) : 1;
    localparam int LW = AW + 2;

    logic signed [PRIORITY_BITS-1:0] prio_mem [SLOTS];
    logic [AW-1:0] kap_mem [SLOTS];
    logic [AW-1:0] pok_mem [SLOTS];

    ihq_pkg::kind_t kind_reg;
    logic [ihq_pkg::KEY_W-1:0] key_reg;
    logic signed [PRIORITY_BITS-1:0] pin_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] mk_reg;
    logic signed [PRIORITY_BITS-1:0] mp_reg;
    logic [AW-1:0] top_reg;
    ihq_pkg::status_t stat_reg;
    logic [PD-1:0] present_reg;
    logic m_valid_reg;
    ihq_pkg::status_t o_status_reg;
    logic [AW-1:0] o_top_reg;
    logic [CW-1:0] o_cnt_reg;

    ihq_pkg::status_t stat_next;
    logic [AW-1:0] top_next, mk_next, pos_next;

    logic signed [PRIORITY_BITS-1:0] prio_qa, prio_qb;
    logic [AW-1:0] kap_qa, kap_qb, pok_q;
    logic [AW-1:0] key_addr, parent, bk, bpos, kap_wd;
    logic [LW-1:0] left, right, cnt_ext;
    logic [AW-1:0] kap_ra, kap_rb, prio_ra, prio_rb;
    logic kap_re, prio_re, kap_we, prio_we;
    logic key_ok, present_bit, empty, full, has_right, big_r;
    logic signed [PRIORITY_BITS-1:0] bp;

    assign key_addr    = AW'(key_reg);
    assign parent      = AW'((pos_reg - AW'(1)) >> 1);
    assign left        = {1'b0, pos_reg, 1'b1};
    assign right       = left + LW'(1);
    assign cnt_ext     = LW'(cnt_reg);
    assign key_ok      = int'(key_reg) < SLOTS;
    assign present_bit = present_reg[key_reg[PW-1:0]];
    assign empty       = (cnt_reg == '0);
    assign full        = (cnt_reg >= CW'(SLOTS));
    assign has_right   = right < cnt_ext;
    assign big_r       = has_right && (prio_qb > prio_qa);
    assign bk          = big_r ? kap_qb : kap_qa;
    assign bp          = big_r ? prio_qb : prio_qa;
    assign bpos        = big_r ? right[AW-1:0] : left[AW-1:0];

    always_comb begin
        sts.chk_done = 1'b1;
        sts.chk_up   = 1'b0;
        sts.chk_dn   = 1'b0;
        sts.chk_last = 1'b0;
        case (kind_reg)
            ihq_pkg::KIND_INSERT: begin
                sts.chk_up   = key_ok && !full && !present_bit;
                sts.chk_done = !sts.chk_up;
            end
            ihq_pkg::KIND_REMOVE: begin
                sts.chk_last = !empty;
                sts.chk_done = empty;
            end
            ihq_pkg::KIND_UPDATE: begin
                sts.chk_up   = key_ok && present_bit && (prio_qa < pin_reg);
                sts.chk_dn   = key_ok && present_bit && (prio_qa > pin_reg);
                sts.chk_done = !sts.chk_up && !sts.chk_dn;
            end
            default: sts.chk_done = 1'b1;
        endcase
    end

    assign sts.root     = (pos_reg == '0);
    assign sts.leaf     = left >= cnt_ext;
    assign sts.up_swap  = prio_qa < mp_reg;
    assign sts.dn_swap  = mp_reg < bp;
    assign sts.out_free = !m_valid_reg || m_tready;

    always_comb begin
        kap_ra = '0;
        kap_rb = AW'(cnt_reg - CW'(1));
        if (cmd.up_rd) begin
            kap_ra = parent;
        end else if (cmd.dn_rd) begin
            kap_ra = left[AW-1:0];
            kap_rb = right[AW-1:0];
        end
    end

    always_comb begin
        prio_ra = key_addr;
        prio_rb = kap_qb;
        if (cmd.upk || cmd.dnk) begin
            prio_ra = kap_qa;
        end else if (cmd.rdlast) begin
            prio_ra = kap_qb;
        end
    end

    assign kap_re  = cmd.look || cmd.up_rd || cmd.dn_rd;
    assign prio_re = cmd.look || cmd.upk || cmd.dnk || cmd.rdlast;
    assign prio_we = cmd.check && (sts.chk_up || sts.chk_dn
                     || (kind_reg == ihq_pkg::KIND_UPDATE && key_ok && present_bit));
    assign kap_we  = (cmd.upp && sts.up_swap) || (cmd.dnp && sts.dn_swap) || cmd.place;

    always_comb begin
        kap_wd = mk_reg;
        if (cmd.upp) begin
            kap_wd = kap_qa;
        end else if (cmd.dnp) begin
            kap_wd = bk;
        end
    end

    always_comb begin
        stat_next = ihq_pkg::ST_OK;
        top_next  = '0;
        mk_next   = key_addr;
        pos_next  = pos_reg;
        case (kind_reg)
            ihq_pkg::KIND_INSERT: begin
                pos_next = AW'(cnt_reg);
                if (!key_ok)          stat_next = ihq_pkg::ST_ABSENT;
                else if (full)        stat_next = ihq_pkg::ST_FULL;
                else if (present_bit) stat_next = ihq_pkg::ST_PRESENT;
            end
            ihq_pkg::KIND_REMOVE: begin
                pos_next = '0;
                mk_next  = kap_qb;
                if (empty) stat_next = ihq_pkg::ST_EMPTY;
                else       top_next  = kap_qa;
            end
            ihq_pkg::KIND_UPDATE: begin
                pos_next = pok_q;
                if (!key_ok || !present_bit)  stat_next = ihq_pkg::ST_ABSENT;
                else if (prio_qa == pin_reg) stat_next = ihq_pkg::ST_UNCHANGED;
            end
            default: begin
                if (empty) stat_next = ihq_pkg::ST_EMPTY;
                else       top_next  = kap_qa;
            end
        endcase
        if (!cmd.check) begin
            pos_next = pos_reg;
        end
        if (cmd.upp && sts.up_swap) begin
            pos_next = parent;
        end else if (cmd.dnp && sts.dn_swap) begin
            pos_next = bpos;
        end
    end

    always_ff @(posedge aclk) begin
        if (prio_we) begin
            prio_mem[key_addr] <= pin_reg;
        end
        if (prio_re) begin
            prio_qa <= prio_mem[prio_ra];
            prio_qb <= prio_mem[prio_rb];
        end
    end

    always_ff @(posedge aclk) begin
        if (kap_we) begin
            kap_mem[pos_reg] <= kap_wd;
        end
        if (kap_re) begin
            kap_qa <= kap_mem[kap_ra];
            kap_qb <= kap_mem[kap_rb];
        end
    end

    always_ff @(posedge aclk) begin
        if (kap_we) begin
            pok_mem[kap_wd] <= pos_reg;
        end
        if (cmd.look) begin
            pok_q <= pok_mem[key_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg <= ihq_pkg::kind_t'(in_kind);
            key_reg  <= in_key;
            pin_reg  <= PRIORITY_BITS'(in_prio);
        end
        if (cmd.check) begin
            top_reg  <= top_next;
            stat_reg <= stat_next;
            mk_reg   <= mk_next;
            mp_reg   <= pin_reg;
        end
        if (cmd.lastp) begin
            mp_reg <= prio_qa;
        end
        pos_reg <= pos_next;
        if (cmd.emit) begin
            o_status_reg <= stat_reg;
            o_top_reg    <= top_reg;
            o_cnt_reg    <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.check && kind_reg == ihq_pkg::KIND_INSERT && sts.chk_up) begin
                cnt_reg <= cnt_reg + CW'(1);
                present_reg[key_reg[PW-1:0]] <= 1'b1;
            end
            if (cmd.check && sts.chk_last) begin
                cnt_reg <= cnt_reg - CW'(1);
                present_reg[kap_qa[PW-1:0]] <= 1'b0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign out_status = o_status_reg;
    assign out_top    = ihq_pkg::KEY_W'(o_top_reg);
    assign out_count  = ihq_pkg::COUNT_OUT_W'(o_cnt_reg);

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(SLOTS))
        else $error("count overflow");
    a_cnt_present: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(present_reg) == int'(cnt_reg))
        else $error("presence flags disagree with count");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("result lost");
`endif

endmodule

// ===== sv/indexed_max_heap_queue_top.sv =====
// channel  | valid/ready         | tdata                                | tuser
// request  | s_tvalid / s_tready | [5:0] key_id, [37:6] priority_req    | [1:0] kind
// result   | m_tvalid / m_tready | [5:0] top_key, [12:6] entry_count    | [2:0] status
// One request at a time; a request that moves nothing skips the heap walk, else it walks one heap level a pass.
// Each pass reads the registered memories before it compares and swaps.
// aresetn clears the count, the presence flags and the result valid flag.
// A new request is taken while a finished result still waits on m_tready.
module indexed_max_heap_queue_top #(
    parameter int SLOTS         = 64,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ihq_pkg::S_TDATA_W-1:0]     s_tdata,  // key_id, priority_req
    input  logic [ihq_pkg::KIND_W-1:0]        s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ihq_pkg::M_TDATA_W-1:0]     m_tdata,  // top_key, entry_count
    output logic [ihq_pkg::STATUS_W-1:0]      m_tuser   // status
);

    ihq_pkg::cmd_t cmd;
    ihq_pkg::sts_t sts;
    logic [ihq_pkg::KEY_W-1:0] top_key;
    logic [ihq_pkg::COUNT_OUT_W-1:0] entry_count;

    ihq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ihq_dp #(
        .SLOTS         (SLOTS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_kind    (s_tuser),
        .in_key     (s_tdata[5:0]),
        .in_prio    (s_tdata[37:6]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (m_tuser),
        .out_top    (top_key),
        .out_count  (entry_count)
    );

    assign m_tdata = {3'b000, entry_count, top_key};

endmodule

// ===== test/indexed_max_heap_queue_top_tb.sv =====
module indexed_max_heap_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        ihq_pkg::status_t status;
        logic [5:0]       top_key;
        logic [6:0]       entry_count;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    indexed_max_heap_queue_top #(.SLOTS(NKEYS), .PRIORITY_BITS(32)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    logic signed [31:0] prio_of_key [NKEYS];
    logic [5:0]         heap_key [NKEYS];
    logic [5:0]         heap_pos [NKEYS];
    logic               queued [NKEYS];
    int unsigned        heap_size;

    answer_t     pending_answers[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned hold_off = 0;
    int unsigned hold_ask = 0;
    int unsigned hold_seen = 0;
    int unsigned rx_wait = 0;

    function automatic logic signed [31:0] prio_at(int unsigned p);
        return prio_of_key[heap_key[p]];
    endfunction

    function automatic void swap_pos(int unsigned a, int unsigned b);
        logic [5:0] ka, kb;
        ka = heap_key[a];
        kb = heap_key[b];
        heap_pos[ka] = 6'(b);
        heap_pos[kb] = 6'(a);
        heap_key[a] = kb;
        heap_key[b] = ka;
    endfunction

    function automatic void swim(int unsigned p);
        int unsigned par;
        while (p > 0) begin
            par = (p - 1) / 2;
            if (prio_at(par) < prio_at(p)) begin
                swap_pos(p, par);
                p = par;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sink(int unsigned p);
        int unsigned l, big;
        forever begin
            l = 2 * p + 1;
            big = l;
            if (l >= heap_size) break;
            if (l + 1 < heap_size && prio_at(l + 1) > prio_at(l)) big = l + 1;
            if (prio_at(p) < prio_at(big)) begin
                swap_pos(p, big);
                p = big;
            end else begin
                break;
            end
        end
    endfunction

    function automatic answer_t heap_apply(ihq_pkg::kind_t k, logic [5:0] key,
                                           logic signed [31:0] pr);
        answer_t a;
        logic signed [31:0] old;
        logic [5:0] top;
        a = '{status: ihq_pkg::ST_OK, top_key: '0, entry_count: '0};
        case (k)
            ihq_pkg::KIND_INSERT: begin
                if (heap_size >= NKEYS) a.status = ihq_pkg::ST_FULL;
                else if (queued[key]) a.status = ihq_pkg::ST_PRESENT;
                else begin
                    prio_of_key[key] = pr;
                    heap_pos[key] = 6'(heap_size);
                    heap_key[heap_size] = key;
                    queued[key] = 1'b1;
                    heap_size++;
                    swim(heap_size - 1);
                end
            end
            ihq_pkg::KIND_REMOVE: begin
                if (heap_size == 0) a.status = ihq_pkg::ST_EMPTY;
                else begin
                    top = heap_key[0];
                    a.top_key = top;
                    swap_pos(0, heap_size - 1);
                    heap_size--;
                    queued[top] = 1'b0;
                    sink(0);
                end
            end
            ihq_pkg::KIND_UPDATE: begin
                if (!queued[key]) a.status = ihq_pkg::ST_ABSENT;
                else begin
                    old = prio_of_key[key];
                    prio_of_key[key] = pr;
                    if (old > pr) sink(32'(heap_pos[key]));
                    else if (old < pr) swim(32'(heap_pos[key]));
                    else a.status = ihq_pkg::ST_UNCHANGED;
                end
            end
            default: begin
                if (heap_size == 0) a.status = ihq_pkg::ST_EMPTY;
                else a.top_key = heap_key[0];
            end
        endcase
        a.entry_count = heap_size[6:0];
        return a;
    endfunction

    task automatic send_request(ihq_pkg::kind_t k, logic [5:0] key, logic signed [31:0] pr,
                                bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {2'b00, pr, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_answers.push_back(heap_apply(k, key, pr));
    endtask

    task automatic drain_answers();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [5:0] some_key();
        return 6'($urandom_range(0, NKEYS - 1));
    endfunction

    function automatic logic signed [31:0] some_prio();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 7)) - 32'sd3;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected transaction status=%0d", m_tuser);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[5:0] !== want.top_key) begin
                    $error("top_key exp %0d got %0d", want.top_key, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[12:6] !== want.entry_count) begin
                    $error("entry_count exp %0d got %0d", want.entry_count, m_tdata[12:6]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        int unsigned w;
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_off  <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            w = $urandom_range(0, 3);
            rx_wait  <= w;
            m_tready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_empty_and_extremes();
        send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        send_request(ihq_pkg::KIND_PEEK, 6'd63, 32'sd0);
        send_request(ihq_pkg::KIND_UPDATE, 6'd5, 32'sd1);
        send_request(ihq_pkg::KIND_INSERT, 6'd0, 32'h8000_0000);
        send_request(ihq_pkg::KIND_INSERT, 6'd63, 32'h7fff_ffff);
        send_request(ihq_pkg::KIND_INSERT, 6'd63, 32'sd4);
        send_request(ihq_pkg::KIND_INSERT, 6'd10, 32'sd7);
        send_request(ihq_pkg::KIND_INSERT, 6'd11, 32'sd7);
        send_request(ihq_pkg::KIND_INSERT, 6'd12, 32'sd7);
        send_request(ihq_pkg::KIND_PEEK, 6'd0, 32'sd0);
        send_request(ihq_pkg::KIND_UPDATE, 6'd10, 32'sd7);
        send_request(ihq_pkg::KIND_UPDATE, 6'd63, -32'sd1);
        send_request(ihq_pkg::KIND_UPDATE, 6'd0, 32'h7fff_ffff);
        send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        drain_answers();
    endtask

    task automatic test_full_queue_backpressure();
        hold_ask++;
        for (int i = 0; i < NKEYS; i++)
            send_request(ihq_pkg::KIND_INSERT, 6'(i), some_prio(), 1);
        send_request(ihq_pkg::KIND_INSERT, 6'd3, 32'sd9);
        send_request(ihq_pkg::KIND_PEEK, 6'd0, 32'sd0);
        drain_answers();
        for (int i = 0; i < NKEYS + 1; i++)
            send_request(ihq_pkg::KIND_REMOVE, 6'd0, 32'sd0);
        drain_answers();
    endtask

    task automatic test_random_mix();
        int r;
        for (int i = 0; i < 700; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_request(ihq_pkg::KIND_INSERT, some_key(), some_prio(), r == 0);
            else if (r < 6)
                send_request(ihq_pkg::KIND_REMOVE, some_key(), some_prio(), r == 4);
            else if (r < 9)
                send_request(ihq_pkg::KIND_UPDATE, some_key(), some_prio());
            else
                send_request(ihq_pkg::KIND_PEEK, some_key(), some_prio());
        end
        drain_answers();
    endtask

    initial begin
        for (int i = 0; i < NKEYS; i++) queued[i] = 1'b0;
        heap_size = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_extremes();
        test_full_queue_backpressure();
        test_random_mix();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ihq_pkg.sv
sv/ihq_ctrl.sv
sv/ihq_dp.sv
sv/indexed_max_heap_queue_top.sv
test/indexed_max_heap_queue_top_tb.sv
